// File: hw/rtl/teq_pkg.sv
// Package for the timed event priority queue: field widths, codes and the
// packed request, response, slot and cell control types.
// No dependencies; every other file of the block imports it.
`default_nettype none

package teq_pkg;

   localparam int unsigned DEADLINE_W          = 48;
   localparam int unsigned DELAY_W             = 32;
   localparam int unsigned OWNER_W             = 16;
   localparam int unsigned COMMAND_W           = 8;
   localparam int unsigned TARGET_W            = 16;
   localparam int unsigned COUNT_OUT_W         = 7;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 64;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_PEEK   = 2'd1,
      MODE_POP    = 2'd2,
      MODE_DELETE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      mode_type               mode;
      logic [OWNER_W-1:0]     owner_id;
      logic [COMMAND_W-1:0]   command_code;
      logic [DELAY_W-1:0]     delay_ms;
      logic [TARGET_W-1:0]    target_id;
      logic [DEADLINE_W-1:0]  current_time;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [OWNER_W-1:0]     event_owner;
      logic [COMMAND_W-1:0]   event_command;
      logic [DEADLINE_W-1:0]  event_deadline;
      logic [TARGET_W-1:0]    event_target;
      logic [COUNT_OUT_W-1:0] removed_count;
      logic [COUNT_OUT_W-1:0] occupancy;
   } rsp_type;

   typedef struct packed {
      logic [DEADLINE_W-1:0] deadline;
      logic [OWNER_W-1:0]    owner;
      logic [COMMAND_W-1:0]  command;
      logic [TARGET_W-1:0]   target;
   } slot_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_POP    = 2'd2,
      CELL_ROTATE = 2'd3
   } cell_op_type;

   // Broadcast to every cell of the row in each cycle.
   typedef struct packed {
      cell_op_type op;
      slot_type    new_slot;
      logic        keep_head;
   } chain_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_EXEC   = 2'd1,
      ST_DELETE = 2'd2
   } state_type;

endpackage

`default_nettype wire

// File: hw/rtl/teq_cell.sv
// One cell of the sorted event row: holds one event and its valid bit and
// picks its next contents from itself, its neighbours, the head or a new event.
// Depends on teq_pkg.
`default_nettype none

module teq_cell
   import teq_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire chain_ctl_type ctl,
   input  wire slot_type      prev_slot,
   input  wire logic          prev_valid,
   input  wire logic          prev_keep,
   input  wire slot_type      next_slot,
   input  wire logic          next_valid,
   input  wire slot_type      head_slot,
   output      slot_type      slot,
   output      logic          valid,
   output      logic          keep
);

   slot_type slot_ff, slot_in;
   logic     valid_ff, valid_in;

   // An event stays put on insert when its deadline is not later than the new one.
   assign keep  = valid_ff && (slot_ff.deadline <= ctl.new_slot.deadline);
   assign slot  = slot_ff;
   assign valid = valid_ff;

   always_comb begin
      slot_in  = slot_ff;
      valid_in = valid_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if (!keep) begin
               if (prev_keep) begin
                  slot_in  = ctl.new_slot;
                  valid_in = 1'b1;
               end else begin
                  slot_in  = prev_slot;
                  valid_in = valid_ff | prev_valid;
               end
            end
         end
         CELL_POP: begin
            slot_in  = next_slot;
            valid_in = next_valid;
         end
         CELL_ROTATE: begin
            // The last held cell takes the departing head back when it is kept.
            if (valid_ff && !next_valid && ctl.keep_head) begin
               slot_in  = head_slot;
               valid_in = 1'b1;
            end else begin
               slot_in  = next_slot;
               valid_in = next_valid;
            end
         end
         default: begin
            slot_in  = slot_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/teq_row.sv
// Row of QUEUE_DEPTH event cells, kept sorted by deadline with the earliest
// event in cell 0. Depends on teq_pkg and teq_cell.
`default_nettype none

module teq_row
   import teq_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire chain_ctl_type          ctl,
   output      slot_type               head_slot,
   output      logic [QUEUE_DEPTH-1:0] valid_vec
);

   slot_type slot_w  [QUEUE_DEPTH];
   logic     valid_w [QUEUE_DEPTH];
   logic     keep_w  [QUEUE_DEPTH];

   assign head_slot = slot_w[0];

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      slot_type prev_slot_w, next_slot_w;
      logic     prev_valid_w, prev_keep_w, next_valid_w;

      // Cell 0 sees an always-kept, always-valid neighbour on its left, so a
      // new earliest event lands there.
      if (i == 0) begin : g_first
         assign prev_slot_w  = '0;
         assign prev_valid_w = 1'b1;
         assign prev_keep_w  = 1'b1;
      end else begin : g_inner_prev
         assign prev_slot_w  = slot_w[i-1];
         assign prev_valid_w = valid_w[i-1];
         assign prev_keep_w  = keep_w[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign next_slot_w  = '0;
         assign next_valid_w = 1'b0;
      end else begin : g_inner_next
         assign next_slot_w  = slot_w[i+1];
         assign next_valid_w = valid_w[i+1];
      end

      teq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .prev_slot  (prev_slot_w),
         .prev_valid (prev_valid_w),
         .prev_keep  (prev_keep_w),
         .next_slot  (next_slot_w),
         .next_valid (next_valid_w),
         .head_slot  (slot_w[0]),
         .slot       (slot_w[i]),
         .valid      (valid_w[i]),
         .keep       (keep_w[i])
      );

      assign valid_vec[i] = valid_w[i];
   end

endmodule

`default_nettype wire

// File: hw/rtl/timed_event_priority_queue.sv
// Timed event priority queue. A command is taken when start is high and busy
// is low; insert, peek and pop give a registered result from the execute
// state, and delete by owner, when events are held, goes on to a delete pass
// in which the row of cells rotates once through every held event and drops those of the owner.
// A new command can be taken in the cycle in which the previous result is
// shown. The result is on rsp_data for exactly one cycle with rsp_valid high
// and cannot be held off. No clearing pass is needed after reset.
// Depends on teq_pkg and teq_row.
`default_nettype none

module timed_event_priority_queue
   import teq_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output      logic    busy,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   output      rsp_type rsp_data
);

   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   state_type            state_ff, state_in;
   req_type              req_ff, req_in;
   logic [DEADLINE_W-1:0] deadline_ff, deadline_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     iter_ff, iter_in;
   logic [CNT_W-1:0]     removed_ff, removed_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   chain_ctl_type          ctl;
   slot_type               head_slot;
   logic [QUEUE_DEPTH-1:0] valid_vec;
   logic                   accept;
   logic [DEADLINE_W:0]    deadline_sum;
   logic                   queue_full;
   logic                   queue_empty;
   logic                   head_match;

   assign accept       = start && !busy;
   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign queue_full   = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign queue_empty  = (count_ff == '0);
   assign head_match   = (head_slot.owner == req_ff.owner_id);

   // Deadline is formed at the transfer and saturates at the top of the range.
   assign deadline_sum = {1'b0, req_data.current_time} + (DEADLINE_W + 1)'(req_data.delay_ms);

   teq_row #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_row (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .head_slot (head_slot),
      .valid_vec (valid_vec)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (req_ff.mode == MODE_DELETE && !queue_empty) begin
               state_in = ST_DELETE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DELETE: begin
            if (iter_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs, cell control and counters.
   always_comb begin
      req_in       = req_ff;
      deadline_in  = deadline_ff;
      count_in     = count_ff;
      iter_in      = iter_ff;
      removed_in   = removed_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;

      ctl.op                = CELL_HOLD;
      ctl.new_slot.deadline = deadline_ff;
      ctl.new_slot.owner    = req_ff.owner_id;
      ctl.new_slot.command  = req_ff.command_code;
      ctl.new_slot.target   = req_ff.target_id;
      ctl.keep_head         = !head_match;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in      = req_data;
               deadline_in = deadline_sum[DEADLINE_W] ? '1 : deadline_sum[DEADLINE_W-1:0];
            end
         end
         ST_EXEC: begin
            case (req_ff.mode)
               MODE_INSERT: begin
                  rsp_valid_in = 1'b1;
                  if (queue_full) begin
                     rsp_data_in.status = STATUS_FULL;
                  end else begin
                     ctl.op   = CELL_INSERT;
                     count_in = count_ff + CNT_W'(1);
                  end
                  rsp_data_in.occupancy = COUNT_OUT_W'(count_in);
               end
               MODE_PEEK, MODE_POP: begin
                  rsp_valid_in = 1'b1;
                  if (queue_empty) begin
                     rsp_data_in.status = STATUS_EMPTY;
                  end else begin
                     rsp_data_in.event_owner    = head_slot.owner;
                     rsp_data_in.event_command  = head_slot.command;
                     rsp_data_in.event_deadline = head_slot.deadline;
                     rsp_data_in.event_target   = head_slot.target;
                     if (req_ff.mode == MODE_POP) begin
                        ctl.op   = CELL_POP;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  rsp_data_in.occupancy = COUNT_OUT_W'(count_in);
               end
               MODE_DELETE: begin
                  removed_in = '0;
                  iter_in    = count_ff;
                  if (queue_empty) begin
                     rsp_valid_in          = 1'b1;
                     rsp_data_in.occupancy = COUNT_OUT_W'(count_ff);
                  end
               end
               default: begin
                  rsp_valid_in = 1'b0;
               end
            endcase
         end
         ST_DELETE: begin
            // Each cycle the head leaves and, unless it belongs to the owner,
            // joins the tail again, so one full turn keeps the order intact.
            ctl.op  = CELL_ROTATE;
            iter_in = iter_ff - CNT_W'(1);
            if (head_match) begin
               removed_in = removed_ff + CNT_W'(1);
               count_in   = count_ff - CNT_W'(1);
            end
            if (iter_ff == CNT_W'(1)) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.removed_count = COUNT_OUT_W'(removed_in);
               rsp_data_in.occupancy     = COUNT_OUT_W'(count_in);
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         iter_ff      <= '0;
         removed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         iter_ff      <= iter_in;
         removed_ff   <= removed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      deadline_ff <= deadline_in;
      rsp_data_ff <= rsp_data_in;
   end

   // The held events always form an unbroken run from cell 0 whose length is
   // the count, checked whenever the block is idle.
   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ($countones(valid_vec) == int'(count_ff)))
      else $error("held count differs from the number of valid cells");

   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ((valid_vec & (valid_vec + 1'b1)) == '0))
      else $error("valid cells do not form a run from the head");

   a_delete_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DELETE) |-> (iter_ff != '0 && iter_ff <= count_ff))
      else $error("delete pass counter out of range");

   a_transfer_gives_result: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.mode != MODE_DELETE) |=> ##1 rsp_valid)
      else $error("no result two cycles after a transfer");

   a_status_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STATUS_OK) |->
         (rsp_data.removed_count == '0 && rsp_data.event_owner == '0))
      else $error("error result carries event or removal data");

endmodule

`default_nettype wire
